@@ design/sdl3d_pkg.sv @@
// ----------------------------------------------------------------------------
// sdl3d_pkg
// Shared types and constants for the 3D spring-damper link force block.
// ----------------------------------------------------------------------------
package sdl3d_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_REGS    = 7;
    localparam int ADDR_WIDTH  = 5;

    typedef enum logic [1:0] {
        CMD_COMPUTE = 2'd0,
        CMD_CLEAR   = 2'd1,
        CMD_LOAD    = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_STIFF   = 3'd0,
        REG_LDAMP   = 3'd1,
        REG_GDAMP   = 3'd2,
        REG_REST    = 3'd3,
        REG_MIN     = 3'd4,
        REG_MAX     = 3'd5,
        REG_SCALE   = 3'd6,
        REG_NONE    = 3'd7
    } t_reg;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQRT,
        ST_L0,
        ST_STRETCH,
        ST_CHANGE,
        ST_FORCE,
        ST_PMUL,
        ST_DIV,
        ST_GMUL,
        ST_AXIS,
        ST_OUT
    } t_state;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // product shifted right with floor (arithmetic shift does exactly that)
    function automatic logic signed [63:0] qshift(input logic signed [65:0] p);
        logic signed [65:0] s;
        s = p >>> FRAC_BITS;
        return s[63:0];
    endfunction

endpackage

@@ design/spring_damper_link_force_3d.sv @@
// ----------------------------------------------------------------------------
// spring_damper_link_force_3d
// Force on two masses joined by a damped spring, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_stall) carries a command and both positions.
//   Compute items produce one result item on (o_valid/i_stall) with the
//   saturated forces on both masses; clear and load items only update the
//   history and produce no item; command 3 is dropped.
//   Registers are to be written through the APB port only while the block is idle; the block does not enforce this.
// Sequence:
//   A compute item runs the 34-step square root, the rest-length, stretch,
//   damping and force steps, then per axis a 68-step division and the
//   damper and axis steps, then the output step. At zero distance the
//   divisions are skipped. History commands act as they are accepted. One
//   item is in flight at a time; o_stall is high from acceptance until the
//   result moves into the output register.
// Reset:
//   Synchronous active-low reset restores the register defaults, clears the
//   position history and sets the previous distance to zero.
// Stall:
//   The result holds on the outputs while i_stall is high.
// ----------------------------------------------------------------------------
module spring_damper_link_force_3d
    import sdl3d_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_command,
    input  logic signed [31:0]   i_mass1_x,
    input  logic signed [31:0]   i_mass1_y,
    input  logic signed [31:0]   i_mass1_z,
    input  logic signed [31:0]   i_mass2_x,
    input  logic signed [31:0]   i_mass2_y,
    input  logic signed [31:0]   i_mass2_z,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_force1_x,
    output logic signed [31:0]   o_force1_y,
    output logic signed [31:0]   o_force1_z,
    output logic signed [31:0]   o_force2_x,
    output logic signed [31:0]   o_force2_y,
    output logic signed [31:0]   o_force2_z,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic signed [31:0] r_regs [NUM_REGS];
    logic signed [31:0] r_prev1 [3];
    logic signed [31:0] r_prev2 [3];
    logic signed [31:0] r_pos1 [3];
    logic signed [31:0] r_pos2 [3];
    logic signed [31:0] r_prev_dist;
    logic signed [31:0] r_f1 [3];
    logic signed [31:0] r_f2 [3];
    t_state             r_state, n_state;
    logic [1:0]         r_axis;
    logic [33:0]        r_dist;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_tmp;
    logic signed [31:0] r_force;
    logic signed [63:0] r_proj;
    logic               r_valid;

    logic [2:0]         w_ridx;
    logic               w_wr;
    logic               w_acc_in;
    logic signed [31:0] w_p1 [3];
    logic signed [31:0] w_p2 [3];
    logic signed [32:0] w_d [3];
    logic [32:0]        w_m [3];
    logic [67:0]        w_sumsq;
    logic               w_start;
    logic               w_is_sqrt;
    logic [67:0]        w_num;
    logic               w_done;
    logic [67:0]        w_res;
    logic signed [32:0] w_dax;
    logic [32:0]        w_max;
    logic [31:0]        w_fmag;
    logic [63:0]        w_pmag;
    logic signed [32:0] w_gd1;
    logic signed [32:0] w_gd2;

    assign pready  = 1'b1;
    assign w_ridx  = paddr[4:2];
    assign w_wr    = psel && penable && pwrite && (w_ridx != REG_NONE);
    assign prdata  = (w_ridx != REG_NONE) ? r_regs[w_ridx] : 32'd0;
    assign o_stall = (r_state != ST_IDLE);
    assign w_acc_in = i_valid && !o_stall;
    assign o_valid = r_valid;

    // in idle the root starts straight from the input item
    always_comb begin
        if (r_state == ST_IDLE) begin
            w_p1[0] = i_mass1_x;
            w_p1[1] = i_mass1_y;
            w_p1[2] = i_mass1_z;
            w_p2[0] = i_mass2_x;
            w_p2[1] = i_mass2_y;
            w_p2[2] = i_mass2_z;
        end else begin
            for (int i = 0; i < 3; i++) begin
                w_p1[i] = r_pos1[i];
                w_p2[i] = r_pos2[i];
            end
        end
        w_sumsq = '0;
        for (int i = 0; i < 3; i++) begin
            w_d[i] = {w_p2[i][31], w_p2[i]} - {w_p1[i][31], w_p1[i]};
            w_m[i] = w_d[i][32] ? 33'(-w_d[i]) : w_d[i][32:0];
            w_sumsq = w_sumsq + 68'(w_m[i] * w_m[i]);
        end
    end

    assign w_dax  = w_d[r_axis];
    assign w_max  = w_dax[32] ? 33'(-w_dax) : w_dax[32:0];
    assign w_fmag = r_force[31] ? 32'(-r_force) : r_force;
    assign w_pmag = 64'(w_fmag) * 64'(w_max);
    assign w_gd1  = {r_prev1[r_axis][31], r_prev1[r_axis]} -
                    {r_pos1[r_axis][31], r_pos1[r_axis]};
    assign w_gd2  = {r_prev2[r_axis][31], r_prev2[r_axis]} -
                    {r_pos2[r_axis][31], r_pos2[r_axis]};

    assign w_start   = (r_state == ST_IDLE && w_acc_in && i_command == CMD_COMPUTE)
                       || (r_state == ST_PMUL && r_dist != 34'd0);
    assign w_is_sqrt = (r_state == ST_IDLE);
    assign w_num     = (r_state == ST_IDLE) ? w_sumsq : 68'(w_pmag);

    sdl3d_seq_unit u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_is_sqrt (w_is_sqrt),
        .i_num     (w_num),
        .i_den     (r_dist),
        .o_done    (w_done),
        .o_result  (w_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (w_acc_in && i_command == CMD_COMPUTE) n_state = ST_SQRT;
            ST_SQRT:    if (w_done) n_state = ST_L0;
            ST_L0:      n_state = ST_STRETCH;
            ST_STRETCH: n_state = ST_CHANGE;
            ST_CHANGE:  n_state = ST_FORCE;
            ST_FORCE:   n_state = ST_PMUL;
            ST_PMUL:    n_state = (r_dist != 34'd0) ? ST_DIV : ST_GMUL;
            ST_DIV:     if (w_done) n_state = ST_GMUL;
            ST_GMUL:    n_state = ST_AXIS;
            ST_AXIS:    n_state = (r_axis == 2'd2) ? ST_OUT : ST_PMUL;
            ST_OUT:     if (!r_valid || !i_stall) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && (!r_valid || !i_stall)) begin
                r_valid <= 1'b1;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs[REG_STIFF] <= '0;
            r_regs[REG_LDAMP] <= '0;
            r_regs[REG_GDAMP] <= '0;
            r_regs[REG_REST]  <= '0;
            r_regs[REG_MIN]   <= '0;
            r_regs[REG_MAX]   <= 32'sd655360000;
            r_regs[REG_SCALE] <= 32'sd65536;
        end else if (w_wr) begin
            r_regs[w_ridx] <= pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_prev1[i] <= '0;
                r_prev2[i] <= '0;
            end
            r_prev_dist <= '0;
        end else if (r_state == ST_IDLE && w_acc_in &&
                     (i_command == CMD_CLEAR || i_command == CMD_LOAD)) begin
            r_prev1[0] <= (i_command == CMD_LOAD) ? i_mass1_x : '0;
            r_prev1[1] <= (i_command == CMD_LOAD) ? i_mass1_y : '0;
            r_prev1[2] <= (i_command == CMD_LOAD) ? i_mass1_z : '0;
            r_prev2[0] <= (i_command == CMD_LOAD) ? i_mass2_x : '0;
            r_prev2[1] <= (i_command == CMD_LOAD) ? i_mass2_y : '0;
            r_prev2[2] <= (i_command == CMD_LOAD) ? i_mass2_z : '0;
            r_prev_dist <= r_regs[REG_REST];
        end else if (r_state == ST_OUT && n_state == ST_IDLE) begin
            for (int i = 0; i < 3; i++) begin
                r_prev1[i] <= r_pos1[i];
                r_prev2[i] <= r_pos2[i];
            end
            r_prev_dist <= sat32(64'(r_dist));
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_pos1[0] <= i_mass1_x;
                r_pos1[1] <= i_mass1_y;
                r_pos1[2] <= i_mass1_z;
                r_pos2[0] <= i_mass2_x;
                r_pos2[1] <= i_mass2_y;
                r_pos2[2] <= i_mass2_z;
                r_axis    <= 2'd0;
            end
            ST_SQRT: begin
                if (w_done) begin
                    r_dist <= w_res[33:0];
                end
            end
            ST_L0: begin
                r_tmp <= 64'(sat32(qshift(66'(r_regs[REG_REST] * r_regs[REG_SCALE]))));
            end
            ST_STRETCH: begin
                r_acc <= qshift(66'(r_regs[REG_STIFF] *
                         sat32($signed({30'd0, r_dist}) - r_tmp)));
            end
            ST_CHANGE: begin
                r_acc <= r_acc + qshift(66'(r_regs[REG_LDAMP] *
                         sat32($signed({30'd0, r_dist}) - 64'(r_prev_dist))));
            end
            ST_FORCE: begin
                if ($signed({30'd0, r_dist}) > 64'(r_regs[REG_MAX]) ||
                    $signed({30'd0, r_dist}) < 64'(r_regs[REG_MIN])) begin
                    r_force <= '0;
                end else begin
                    r_force <= sat32(r_acc);
                end
            end
            ST_PMUL: begin
                r_proj <= '0;
            end
            ST_DIV: begin
                if (w_done) begin
                    r_proj <= (r_force[31] != w_dax[32]) ? -$signed(w_res[63:0])
                                                         : $signed(w_res[63:0]);
                end
            end
            ST_GMUL: begin
                r_acc <= qshift(66'(w_gd1 * r_regs[REG_GDAMP]));
                r_tmp <= qshift(66'(w_gd2 * r_regs[REG_GDAMP]));
            end
            ST_AXIS: begin
                r_f1[r_axis] <= sat32(r_proj + r_acc);
                r_f2[r_axis] <= sat32(r_tmp - r_proj);
                r_axis       <= r_axis + 2'd1;
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && (!r_valid || !i_stall)) begin
            o_force1_x <= r_f1[0];
            o_force1_y <= r_f1[1];
            o_force1_z <= r_f1[2];
            o_force2_x <= r_f2[0];
            o_force2_y <= r_f2[1];
            o_force2_z <= r_f2[2];
        end
    end

endmodule

@@ design/sdl3d_seq_unit.sv @@
// ----------------------------------------------------------------------------
// sdl3d_seq_unit
// Shared bit-serial unit: 34-step square root or 68-by-34-bit restoring division.
// ----------------------------------------------------------------------------
module sdl3d_seq_unit
    import sdl3d_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_is_sqrt,
    input  logic [67:0]  i_num,
    input  logic [33:0]  i_den,
    output logic         o_done,
    output logic [67:0]  o_result
);

    t_div_state   r_state, n_state;
    logic [67:0]  r_num;
    logic [69:0]  r_rem;
    logic [67:0]  r_res;
    logic [33:0]  r_den;
    logic [6:0]   r_cnt;
    logic         r_sqrt;
    logic [69:0]  w_rem_sh;
    logic [69:0]  w_trial;
    logic         w_ge;

    always_comb begin
        if (r_sqrt) begin
            w_rem_sh = {r_rem[67:0], r_num[67:66]};
            w_trial  = {r_res[67:0], 2'b01};
        end else begin
            w_rem_sh = {r_rem[68:0], r_num[67]};
            w_trial  = {36'd0, r_den};
        end
        w_ge = (w_rem_sh >= w_trial);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DIV_IDLE: if (i_start) n_state = DIV_RUN;
            DIV_RUN:  if (r_cnt == 7'd0) n_state = DIV_DONE;
            DIV_DONE: n_state = DIV_IDLE;
            default:  n_state = DIV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == DIV_IDLE && i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_res  <= '0;
            r_sqrt <= i_is_sqrt;
            r_cnt  <= i_is_sqrt ? 7'd33 : 7'd67;
        end else if (r_state == DIV_RUN) begin
            r_num <= r_sqrt ? {r_num[65:0], 2'b00} : {r_num[66:0], 1'b0};
            r_rem <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_res <= {r_res[66:0], w_ge};
            r_cnt <= r_cnt - 7'd1;
        end
    end

    assign o_done   = (r_state == DIV_DONE);
    assign o_result = r_res;

endmodule

@@ design/sdl3d_checker.sv @@
// ----------------------------------------------------------------------------
// sdl3d_checker
// Port-level checks for the spring-damper link block.
// ----------------------------------------------------------------------------
module sdl3d_checker
    import sdl3d_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_force1_x,
    input logic [31:0] o_force2_x,
    input logic        pready
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_force1_x) && $stable(o_force2_x))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without busy period");

    a_rdy: assert property (@(posedge i_clk) pready)
        else $error("pready low");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !o_stall)
        else $error("reset not clean");

endmodule

bind spring_damper_link_force_3d sdl3d_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_force1_x (o_force1_x),
    .o_force2_x (o_force2_x),
    .pready     (pready)
);
